// ----- src/sqvs_pkg.sv -----
// Shared types, constants and helper functions of the sprite quad vertex setup block.
`timescale 1ns / 1ps

package sqvs_pkg;

    // Angle format: 2^ANGLE_BITS is one full turn
    localparam int ANGLE_BITS = 16;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int ANG_SHIFT = 32 - ANGLE_BITS;

    // CORDIC
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
    };

    // Divider: dividend width equals its pipeline depth
    localparam int DIV_W = 25;
    localparam int DEN_W = 9;
    localparam int DIV_LAT = DIV_W;

    // Front timing: UV ready after three chained divisions
    localparam int FRONT_DL = 3 * DIV_LAT;
    localparam int ANG_DL = FRONT_DL - CORDIC_LAT;

    // Register map
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    localparam int QDEPTH = 4;

    // Per-sprite setup record passed from front to back
    typedef struct packed {
        logic signed [25:0] mid2x;
        logic signed [25:0] mid2y;
        logic signed [55:0] wc;
        logic signed [55:0] ws;
        logic signed [55:0] hc;
        logic signed [55:0] hs;
        logic [16:0] u0;
        logic [16:0] u1;
        logic [16:0] v0;
        logic [16:0] v1;
    } setup_rec_t;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] den);
        logic [DEN_W:0] rs;
        logic [DEN_W:0] diff;
        rs = {rem, nbit};
        diff = rs - {1'b0, den};
        if (rs >= {1'b0, den}) begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, rs[DEN_W-1:0]};
    endfunction

endpackage

// ----- src/sqvs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module sqvs_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sqvs_pkg::DIV_W-1:0]  num_i,
    input  logic [sqvs_pkg::DEN_W-1:0]  den_i,
    output logic [sqvs_pkg::DIV_W-1:0]  quo_o,
    output logic [sqvs_pkg::DEN_W-1:0]  rem_o
);

    logic [sqvs_pkg::DIV_W-1:0] num_reg [sqvs_pkg::DIV_W];
    logic [sqvs_pkg::DIV_W-1:0] quo_reg [sqvs_pkg::DIV_W];
    logic [sqvs_pkg::DIV_W-1:0] quo_next [sqvs_pkg::DIV_W];
    logic [sqvs_pkg::DEN_W-1:0] rem_reg [sqvs_pkg::DIV_W];
    logic [sqvs_pkg::DEN_W-1:0] den_reg [sqvs_pkg::DIV_W];
    logic [sqvs_pkg::DEN_W:0]   st      [sqvs_pkg::DIV_W];

    // step results and partial quotients of every stage
    always_comb begin
        st[0] = sqvs_pkg::div_step('0, num_i[sqvs_pkg::DIV_W-1], den_i);
        quo_next[0] = '0;
        quo_next[0][sqvs_pkg::DIV_W-1] = st[0][sqvs_pkg::DEN_W];
        for (int k = 1; k < sqvs_pkg::DIV_W; k++) begin
            st[k] = sqvs_pkg::div_step(rem_reg[k-1],
                                       num_reg[k-1][sqvs_pkg::DIV_W-1-k],
                                       den_reg[k-1]);
            quo_next[k] = quo_reg[k-1];
            quo_next[k][sqvs_pkg::DIV_W-1-k] = st[k][sqvs_pkg::DEN_W];
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= num_i;
            den_reg[0] <= den_i;
            rem_reg[0] <= st[0][sqvs_pkg::DEN_W-1:0];
            quo_reg[0] <= quo_next[0];
            for (int k = 1; k < sqvs_pkg::DIV_W; k++) begin
                num_reg[k] <= num_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= st[k][sqvs_pkg::DEN_W-1:0];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo_o = quo_reg[sqvs_pkg::DIV_W-1];
    assign rem_o = rem_reg[sqvs_pkg::DIV_W-1];

endmodule

// ----- src/sqvs_cordic.sv -----
// Pipelined CORDIC giving cosine and sine in Q2.30 from a binary angle.
`timescale 1ns / 1ps

module sqvs_cordic (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        angle_i,
    output logic signed [31:0] cos_o,
    output logic signed [31:0] sin_o
);

    logic signed [32:0] x_reg [sqvs_pkg::CORDIC_STEPS];
    logic signed [32:0] y_reg [sqvs_pkg::CORDIC_STEPS];
    logic signed [33:0] z_reg [sqvs_pkg::CORDIC_STEPS];
    logic [1:0]         q_reg [sqvs_pkg::CORDIC_STEPS];
    logic signed [32:0] x_next [sqvs_pkg::CORDIC_STEPS];
    logic signed [32:0] y_next [sqvs_pkg::CORDIC_STEPS];
    logic signed [33:0] z_next [sqvs_pkg::CORDIC_STEPS];
    logic [31:0] phase;
    logic [31:0] phase_rnd;
    logic [31:0] rr;
    logic [1:0]  q0;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;

    // quadrant fold and the rotation iterations
    always_comb begin
        logic signed [32:0] xi;
        logic signed [32:0] yi;
        logic signed [33:0] zi;
        phase = 32'(({16'd0, angle_i} & sqvs_pkg::ANG_MASK) << sqvs_pkg::ANG_SHIFT);
        phase_rnd = phase + 32'h2000_0000;
        q0 = phase_rnd[31:30];
        rr = phase - {q0, 30'd0};
        xi = sqvs_pkg::CORDIC_GAIN;
        yi = '0;
        zi = {{2{rr[31]}}, rr};
        for (int i = 0; i < sqvs_pkg::CORDIC_STEPS; i++) begin
            if (!zi[33]) begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - $signed({2'b00, sqvs_pkg::ATAN_TURN[i]});
            end else begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + $signed({2'b00, sqvs_pkg::ATAN_TURN[i]});
            end
            // this stage's registers feed the next iteration
            xi = x_reg[i];
            yi = y_reg[i];
            zi = z_reg[i];
        end
    end

    // quadrant unfold
    always_comb begin
        logic signed [32:0] xl;
        logic signed [32:0] yl;
        xl = x_reg[sqvs_pkg::CORDIC_STEPS-1];
        yl = y_reg[sqvs_pkg::CORDIC_STEPS-1];
        unique case (q_reg[sqvs_pkg::CORDIC_STEPS-1])
            2'd0: begin
                cos_next = 32'(xl);
                sin_next = 32'(yl);
            end
            2'd1: begin
                cos_next = 32'(-yl);
                sin_next = 32'(xl);
            end
            2'd2: begin
                cos_next = 32'(-xl);
                sin_next = 32'(-yl);
            end
            default: begin
                cos_next = 32'(yl);
                sin_next = 32'(-xl);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= q0;
            for (int i = 0; i < sqvs_pkg::CORDIC_STEPS; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            for (int i = 1; i < sqvs_pkg::CORDIC_STEPS; i++) begin
                q_reg[i] <= q_reg[i-1];
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

// ----- src/sqvs_front.sv -----
// Front end: accepts sprites, derives tile UV, sine/cosine and size products.
`timescale 1ns / 1ps

module sqvs_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [8:0]             cols_i,
    input  logic [8:0]             rows_i,
    input  logic                   in_valid_i,
    output logic                   in_ready_o,
    input  logic signed [23:0]     pos_x_i,
    input  logic signed [23:0]     pos_y_i,
    input  logic [22:0]            width_i,
    input  logic [22:0]            height_i,
    input  logic [15:0]            angle_i,
    input  logic [15:0]            tile_i,
    input  logic                   centered_i,
    output logic                   rec_valid_o,
    output sqvs_pkg::setup_rec_t   rec_o,
    input  logic                   q_full_i
);

    localparam int L = sqvs_pkg::DIV_LAT;
    localparam int FD = sqvs_pkg::FRONT_DL;

    logic adv;
    logic [8:0] cols_eff;
    logic [8:0] rows_eff;

    // input register
    logic        r0_valid_reg;
    logic signed [23:0] px_reg;
    logic signed [23:0] py_reg;
    logic [22:0] w_reg;
    logic [22:0] h_reg;
    logic [15:0] ang_reg;
    logic [15:0] tile_reg;
    logic        cen_reg;

    // delay lines
    logic        vld_dl   [FD];
    logic signed [25:0] mx_dl [FD];
    logic signed [25:0] my_dl [FD];
    logic [22:0] w_dl     [FD];
    logic [22:0] h_dl     [FD];
    logic [15:0] ang_dl   [sqvs_pkg::ANG_DL];
    logic [16:0] u0_dl    [L];
    logic [16:0] u1_dl    [L];

    logic signed [25:0] mid2x;
    logic signed [25:0] mid2y;

    logic [sqvs_pkg::DIV_W-1:0] quo1, quo2, quo3, quo4, quo5, quo6;
    logic [8:0] rem1, rem2, rem3, rem4, rem5, rem6;
    logic [9:0] col_p1;
    logic [9:0] row_p1;
    logic signed [31:0] c_val;
    logic signed [31:0] s_val;

    logic rec_valid_reg;
    sqvs_pkg::setup_rec_t rec_reg;

    // whole pipeline moves unless a finished record cannot enter the queue
    assign adv = !(rec_valid_reg && q_full_i);
    assign in_ready_o = adv;

    assign cols_eff = (cols_i == 9'd0) ? 9'd1 : cols_i;
    assign rows_eff = (rows_i == 9'd0) ? 9'd1 : rows_i;

    // middle at twice the input scale
    assign mid2x = {px_reg[23], px_reg, 1'b0} + (cen_reg ? 26'sd0 : $signed({3'b0, w_reg}));
    assign mid2y = {py_reg[23], py_reg, 1'b0} + (cen_reg ? 26'sd0 : $signed({3'b0, h_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_valid_reg <= 1'b0;
        end else if (adv) begin
            r0_valid_reg <= in_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg   <= pos_x_i;
            py_reg   <= pos_y_i;
            w_reg    <= width_i;
            h_reg    <= height_i;
            ang_reg  <= angle_i;
            tile_reg <= tile_i;
            cen_reg  <= centered_i;
        end
    end

    // tile column and the quotient by columns
    sqvs_div u_div_col (
        .aclk  (aclk),
        .en    (adv),
        .num_i ({9'd0, tile_reg}),
        .den_i (cols_eff),
        .quo_o (quo1),
        .rem_o (rem1)
    );

    // tile row
    sqvs_div u_div_row (
        .aclk  (aclk),
        .en    (adv),
        .num_i (quo1),
        .den_i (rows_eff),
        .quo_o (quo2),
        .rem_o (rem2)
    );

    assign col_p1 = {1'b0, rem1} + 10'd1;
    assign row_p1 = {1'b0, rem2} + 10'd1;

    // u0, u1 rounded fractions
    sqvs_div u_div_u0 (
        .aclk  (aclk),
        .en    (adv),
        .num_i (25'({rem1, 16'd0}) + 25'(cols_eff >> 1)),
        .den_i (cols_eff),
        .quo_o (quo3),
        .rem_o (rem3)
    );

    sqvs_div u_div_u1 (
        .aclk  (aclk),
        .en    (adv),
        .num_i (25'({col_p1, 16'd0}) + 25'(cols_eff >> 1)),
        .den_i (cols_eff),
        .quo_o (quo4),
        .rem_o (rem4)
    );

    // v0, v1 rounded fractions
    sqvs_div u_div_v0 (
        .aclk  (aclk),
        .en    (adv),
        .num_i (25'({rem2, 16'd0}) + 25'(rows_eff >> 1)),
        .den_i (rows_eff),
        .quo_o (quo5),
        .rem_o (rem5)
    );

    sqvs_div u_div_v1 (
        .aclk  (aclk),
        .en    (adv),
        .num_i (25'({row_p1, 16'd0}) + 25'(rows_eff >> 1)),
        .den_i (rows_eff),
        .quo_o (quo6),
        .rem_o (rem6)
    );

    // started late so that sine/cosine land with the UV results
    sqvs_cordic u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .angle_i (ang_dl[sqvs_pkg::ANG_DL-1]),
        .cos_o   (c_val),
        .sin_o   (s_val)
    );

    // valid delay line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FD; k++) begin
                vld_dl[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_dl[0] <= r0_valid_reg;
            for (int k = 1; k < FD; k++) begin
                vld_dl[k] <= vld_dl[k-1];
            end
        end
    end

    // payload delay lines
    always_ff @(posedge aclk) begin
        if (adv) begin
            mx_dl[0]  <= mid2x;
            my_dl[0]  <= mid2y;
            w_dl[0]   <= w_reg;
            h_dl[0]   <= h_reg;
            ang_dl[0] <= ang_reg;
            u0_dl[0]  <= quo3[16:0];
            u1_dl[0]  <= quo4[16:0];
            for (int k = 1; k < FD; k++) begin
                mx_dl[k] <= mx_dl[k-1];
                my_dl[k] <= my_dl[k-1];
                w_dl[k]  <= w_dl[k-1];
                h_dl[k]  <= h_dl[k-1];
            end
            for (int k = 1; k < sqvs_pkg::ANG_DL; k++) begin
                ang_dl[k] <= ang_dl[k-1];
            end
            for (int k = 1; k < L; k++) begin
                u0_dl[k] <= u0_dl[k-1];
                u1_dl[k] <= u1_dl[k-1];
            end
        end
    end

    // size times sine/cosine, one record register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
        end else if (adv) begin
            rec_valid_reg <= vld_dl[FD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rec_reg.mid2x <= mx_dl[FD-1];
            rec_reg.mid2y <= my_dl[FD-1];
            rec_reg.wc <= $signed({1'b0, w_dl[FD-1]}) * c_val;
            rec_reg.ws <= $signed({1'b0, w_dl[FD-1]}) * s_val;
            rec_reg.hc <= $signed({1'b0, h_dl[FD-1]}) * c_val;
            rec_reg.hs <= $signed({1'b0, h_dl[FD-1]}) * s_val;
            rec_reg.u0 <= u0_dl[L-1];
            rec_reg.u1 <= u1_dl[L-1];
            rec_reg.v0 <= quo5[16:0];
            rec_reg.v1 <= quo6[16:0];
        end
    end

    assign rec_valid_o = rec_valid_reg;
    assign rec_o = rec_reg;

endmodule

// ----- src/sqvs_queue.sv -----
// Short FIFO of setup records between front and back.
`timescale 1ns / 1ps

module sqvs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_i,
    input  sqvs_pkg::setup_rec_t data_i,
    output logic                 full_o,
    input  logic                 pop_i,
    output logic                 valid_o,
    output sqvs_pkg::setup_rec_t data_o
);

    localparam int AW = $clog2(sqvs_pkg::QDEPTH);

    sqvs_pkg::setup_rec_t mem [sqvs_pkg::QDEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;
    logic do_push;
    logic do_pop;

    assign full_o  = (cnt_reg == (AW+1)'(sqvs_pkg::QDEPTH));
    assign valid_o = (cnt_reg != '0);
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && valid_o;
    assign data_o  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= data_i;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

// ----- src/sqvs_back.sv -----
// Back end: walks the four corners of a record and forms saturated vertices.
`timescale 1ns / 1ps

module sqvs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid_i,
    input  sqvs_pkg::setup_rec_t rec_i,
    output logic                 q_pop_o,
    output logic                 m_valid_o,
    input  logic                 m_ready_i,
    output logic [1:0]           corner_o,
    output logic signed [25:0]   vx_o,
    output logic signed [25:0]   vy_o,
    output logic [16:0]          tex_u_o,
    output logic [16:0]          tex_v_o,
    output logic                 last_o
);

    localparam logic signed [57:0] HALF = 58'sd1 << 30;
    localparam logic signed [57:0] VMAX = 58'sd33554431;
    localparam logic signed [57:0] VMIN = -58'sd33554432;

    logic [1:0] corner_reg;
    logic       m_valid_reg;
    logic [1:0] oc_reg;
    logic signed [25:0] vx_reg;
    logic signed [25:0] vy_reg;
    logic [16:0] u_reg;
    logic [16:0] v_reg;
    logic load;
    logic take;
    logic sx_pos;
    logic sy_pos;
    logic signed [57:0] acc_x;
    logic signed [57:0] acc_y;
    logic signed [57:0] tx;
    logic signed [57:0] ty;
    logic signed [25:0] vx_next;
    logic signed [25:0] vy_next;

    assign load = !m_valid_reg || m_ready_i;
    assign take = load && q_valid_i;
    assign q_pop_o = take && (corner_reg == sqvs_pkg::CORNER_LAST);

    // corner signs: right for corners 2,3; top for corners 0,3
    assign sx_pos = corner_reg[1];
    assign sy_pos = (corner_reg[0] == corner_reg[1]);

    // rotated offsets plus the middle, rounded half up
    always_comb begin
        logic signed [57:0] t_wc;
        logic signed [57:0] t_ws;
        logic signed [57:0] t_hc;
        logic signed [57:0] t_hs;
        t_wc = sx_pos ? 58'(rec_i.wc) : -58'(rec_i.wc);
        t_ws = sx_pos ? 58'(rec_i.ws) : -58'(rec_i.ws);
        t_hc = sy_pos ? 58'(rec_i.hc) : -58'(rec_i.hc);
        t_hs = sy_pos ? 58'(rec_i.hs) : -58'(rec_i.hs);
        acc_x = t_wc - t_hs;
        acc_y = t_ws + t_hc;
        tx = ((58'(rec_i.mid2x) <<< 30) + acc_x + HALF) >>> 31;
        ty = ((58'(rec_i.mid2y) <<< 30) + acc_y + HALF) >>> 31;
        priority if (tx > VMAX) begin
            vx_next = 26'(VMAX);
        end else if (tx < VMIN) begin
            vx_next = 26'(VMIN);
        end else begin
            vx_next = 26'(tx);
        end
        priority if (ty > VMAX) begin
            vy_next = 26'(VMAX);
        end else if (ty < VMIN) begin
            vy_next = 26'(VMIN);
        end else begin
            vy_next = 26'(ty);
        end
    end

    // corner counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                corner_reg <= corner_reg + 2'd1;
            end
            if (load) begin
                m_valid_reg <= q_valid_i;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (take) begin
            oc_reg <= corner_reg;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            u_reg  <= sx_pos ? rec_i.u1 : rec_i.u0;
            v_reg  <= sy_pos ? rec_i.v1 : rec_i.v0;
        end
    end

    assign m_valid_o = m_valid_reg;
    assign corner_o  = oc_reg;
    assign vx_o      = vx_reg;
    assign vy_o      = vy_reg;
    assign tex_u_o   = u_reg;
    assign tex_v_o   = v_reg;
    assign last_o    = (oc_reg == sqvs_pkg::CORNER_LAST);

endmodule

// ----- src/sprite_quad_vertex_setup_top.sv -----
// Top level of the sprite quad vertex setup block: ports, registers, front/queue/back.
//
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | one sprite request per accepted beat
//  m_       | out       | four corner vertices per sprite, tlast on corner 3
//  APB      | in/out    | sheet_columns at 0x0, sheet_rows at 0x4
//
// Sustained throughput is set by the back end issuing one corner per cycle while
// m_tready is high, four corners per sprite. The path from request to first corner is set by
// three chained 25-stage pipelined dividers for the tile UV. Reset is
// synchronous and active low and clears all valid state. A stall on m_ fills
// the 4-entry record queue and then holds the front pipeline and s_tready.
`timescale 1ns / 1ps

module sprite_quad_vertex_setup_top (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // sprite input
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[23:0], pos_y[47:24], width[70:48], height[93:71], angle[109:94],
    // tile_index[125:110], zero[127:126]
    input  logic [127:0] s_tdata,
    // centered[0]
    input  logic         s_tuser,
    // vertex output
    output logic         m_tvalid,
    input  logic         m_tready,
    // corner[1:0], vx[27:2], vy[53:28], tex_u[70:54], tex_v[87:71]
    output logic [87:0]  m_tdata,
    output logic         m_tlast
);

    logic [8:0] cols_reg;
    logic [8:0] rows_reg;
    logic       wr_en;

    logic rec_valid;
    sqvs_pkg::setup_rec_t rec_f;
    sqvs_pkg::setup_rec_t rec_q;
    logic q_full;
    logic q_valid;
    logic q_pop;

    logic [1:0] corner;
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic [16:0] tex_u;
    logic [16:0] tex_v;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 9'd1;
            rows_reg <= 9'd1;
        end else if (wr_en) begin
            unique case (paddr[2])
                sqvs_pkg::REG_COLS: cols_reg <= pwdata[8:0];
                sqvs_pkg::REG_ROWS: rows_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sqvs_pkg::REG_COLS: prdata = {23'd0, cols_reg};
            sqvs_pkg::REG_ROWS: prdata = {23'd0, rows_reg};
            default:            prdata = '0;
        endcase
    end

    sqvs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cols_i      (cols_reg),
        .rows_i      (rows_reg),
        .in_valid_i  (s_tvalid),
        .in_ready_o  (s_tready),
        .pos_x_i     ($signed(s_tdata[23:0])),
        .pos_y_i     ($signed(s_tdata[47:24])),
        .width_i     (s_tdata[70:48]),
        .height_i    (s_tdata[93:71]),
        .angle_i     (s_tdata[109:94]),
        .tile_i      (s_tdata[125:110]),
        .centered_i  (s_tuser),
        .rec_valid_o (rec_valid),
        .rec_o       (rec_f),
        .q_full_i    (q_full)
    );

    sqvs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (rec_valid),
        .data_i  (rec_f),
        .full_o  (q_full),
        .pop_i   (q_pop),
        .valid_o (q_valid),
        .data_o  (rec_q)
    );

    sqvs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_valid),
        .rec_i     (rec_q),
        .q_pop_o   (q_pop),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .corner_o  (corner),
        .vx_o      (vx),
        .vy_o      (vy),
        .tex_u_o   (tex_u),
        .tex_v_o   (tex_v),
        .last_o    (m_tlast)
    );

    assign m_tdata = {tex_v, tex_u, vy, vx, corner};

endmodule
